FILE: rtl/core/websocket_frame_builder_macros.svh
// Assertion macros shared by the frame builder RTL.
`ifndef WEBSOCKET_FRAME_BUILDER_MACROS_SVH
`define WEBSOCKET_FRAME_BUILDER_MACROS_SVH

// Implication checked at every aclk edge outside reset.
`define WSFB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wsfb implication check failed");

// Condition that must hold at every aclk edge outside reset.
`define WSFB_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("wsfb invariant check failed");

`endif

FILE: rtl/core/wsfb_pkg.sv
// Types, constants and helper functions for the WebSocket frame builder.
`timescale 1ns / 1ps
`default_nettype none

package wsfb_pkg;

    localparam int LEN_W     = 31;
    localparam int KEY_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int OPC_W     = 4;
    localparam int HDR_MAX   = 14;
    localparam int IDX_W     = $clog2(HDR_MAX);
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    localparam logic [6:0]       LEN_CODE_16   = 7'h7E;
    localparam logic [6:0]       LEN_CODE_64   = 7'h7F;
    localparam logic [LEN_W-1:0] SHORT_LEN_LIM = 31'd126;
    localparam logic [LEN_W-1:0] MID_LEN_MAX   = 31'd65535;
    localparam logic [IDX_W-1:0] EXT_NONE      = 4'd0;
    localparam logic [IDX_W-1:0] EXT_16        = 4'd2;
    localparam logic [IDX_W-1:0] EXT_64        = 4'd8;
    localparam logic [IDX_W-1:0] BASE_HDR      = 4'd2;
    localparam logic [IDX_W-1:0] KEY_BYTES     = 4'd4;

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_PAYLOAD = 1'b1
    } req_t;

    typedef struct packed {
        req_t              req_type;
        logic [LEN_W-1:0]  payload_length;
        logic [OPC_W-1:0]  frame_opcode;
        logic              final_fragment;
        logic              mask_enable;
        logic [KEY_W-1:0]  mask_key;
        logic [BYTE_W-1:0] payload_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              frame_end;
        logic              unexpected_byte;
    } res_t;

    typedef struct packed {
        logic [LEN_W-1:0] bytes_remaining;
        logic [1:0]       mask_phase;
        logic [KEY_W-1:0] held_mask_key;
        logic             masking_on;
        logic             frame_open;
    } frame_state_t;

    // Key byte by index, index 3 is the most significant byte.
    function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                   input logic [1:0] sel);
        return key[sel*BYTE_W +: BYTE_W];
    endfunction

    // Byte of the 64-bit big-endian length, index 0 is the least significant.
    function automatic logic [BYTE_W-1:0] len_byte(input logic [LEN_W-1:0] len,
                                                   input logic [2:0] sel);
        logic [63:0] wide;
        wide = {{(64-LEN_W){1'b0}}, len};
        return wide[sel*BYTE_W +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wsfb_byte_gen.sv
// Selects one output byte of the held item and computes the frame state after it.
`timescale 1ns / 1ps
`default_nettype none

module wsfb_byte_gen (
    input  wire wsfb_pkg::item_t        item,
    input  wire [wsfb_pkg::IDX_W-1:0]   idx,
    input  wire wsfb_pkg::frame_state_t state,
    output wsfb_pkg::res_t              res,
    output wsfb_pkg::frame_state_t      state_next
);

    logic                          is_short;
    logic                          is_mid;
    logic [wsfb_pkg::IDX_W-1:0]    n_ext;
    logic [wsfb_pkg::IDX_W-1:0]    hdr_cnt;
    logic [wsfb_pkg::IDX_W-1:0]    len_end;
    logic [wsfb_pkg::IDX_W-1:0]    len_pos;
    logic [wsfb_pkg::IDX_W-1:0]    key_pos;
    logic [6:0]                    len_code;
    logic [wsfb_pkg::BYTE_W-1:0]   hdr_byte;
    logic                          hdr_last;
    logic [wsfb_pkg::LEN_W-1:0]    rem_dec;
    logic [wsfb_pkg::BYTE_W-1:0]   mask_byte;

    assign is_short = item.payload_length < wsfb_pkg::SHORT_LEN_LIM;
    assign is_mid   = item.payload_length <= wsfb_pkg::MID_LEN_MAX;
    assign n_ext    = is_short ? wsfb_pkg::EXT_NONE :
                      (is_mid ? wsfb_pkg::EXT_16 : wsfb_pkg::EXT_64);
    assign len_end  = wsfb_pkg::BASE_HDR + n_ext;
    assign hdr_cnt  = len_end + (item.mask_enable ? wsfb_pkg::KEY_BYTES : '0);
    assign hdr_last = idx == (hdr_cnt - 4'd1);
    // distance from the least significant length byte
    assign len_pos  = len_end - 4'd1 - idx;
    assign key_pos  = idx - len_end;
    assign len_code = is_short ? item.payload_length[6:0] :
                      (is_mid ? wsfb_pkg::LEN_CODE_16 : wsfb_pkg::LEN_CODE_64);

    always_comb begin
        if (idx == 4'd0) begin
            hdr_byte = {item.final_fragment, 3'b000, item.frame_opcode};
        end else if (idx == 4'd1) begin
            hdr_byte = {item.mask_enable, len_code};
        end else if (idx < len_end) begin
            hdr_byte = wsfb_pkg::len_byte(item.payload_length, len_pos[2:0]);
        end else begin
            hdr_byte = wsfb_pkg::key_byte(item.mask_key, ~key_pos[1:0]);
        end
    end

    assign rem_dec   = state.bytes_remaining - 31'd1;
    assign mask_byte = state.masking_on ?
                       wsfb_pkg::key_byte(state.held_mask_key, ~state.mask_phase) : '0;

    always_comb begin
        state_next = state;
        res        = '0;
        case (item.req_type)
            wsfb_pkg::REQ_START: begin
                res.out_byte    = hdr_byte;
                res.last_of_run = hdr_last;
                res.frame_end   = hdr_last && (item.payload_length == '0);
                state_next.bytes_remaining = item.payload_length;
                state_next.mask_phase      = 2'd0;
                state_next.held_mask_key   = item.mask_key;
                state_next.masking_on      = item.mask_enable;
                state_next.frame_open      = item.payload_length != '0;
            end
            wsfb_pkg::REQ_PAYLOAD: begin
                res.last_of_run = 1'b1;
                if (!state.frame_open) begin
                    res.unexpected_byte = 1'b1;
                end else begin
                    res.out_byte               = item.payload_byte ^ mask_byte;
                    res.frame_end              = rem_dec == '0;
                    state_next.mask_phase      = state.mask_phase + 2'd1;
                    state_next.bytes_remaining = rem_dec;
                    state_next.frame_open      = rem_dec != '0;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/wsfb_out_reg.sv
// Result register driving the master stream.
`timescale 1ns / 1ps
`default_nettype none

module wsfb_out_reg (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               push,
    input  wire wsfb_pkg::res_t               res,
    output logic                              can_take,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [wsfb_pkg::M_TDATA_W-1:0]    m_tdata,   // out_byte
    output logic                              m_tlast,   // last_of_run
    output logic [wsfb_pkg::M_TUSER_W-1:0]    m_tuser    // frame_end, unexpected_byte
);

    logic           valid_reg;
    logic           valid_next;
    wsfb_pkg::res_t res_reg;
    wsfb_pkg::res_t res_next;

    assign can_take = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (can_take) begin
            valid_next = push;
            if (push) begin
                res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.out_byte;
    assign m_tlast  = res_reg.last_of_run;
    assign m_tuser  = {res_reg.unexpected_byte, res_reg.frame_end};

endmodule

`default_nettype wire

FILE: rtl/core/websocket_frame_builder.sv
// Items are registered in item_reg and result bytes in the single result register,
// which takes one byte per cycle unless the master stalls: one byte for a payload
// item, one per header byte (2 to 14) for a start item. An item is taken as the last
// byte of the held one is pushed, or when none is held, also while a result waits.
// Reset (aresetn low, synchronous) empties both registers and closes any frame.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_builder_macros.svh"

module websocket_frame_builder (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // payload_length, frame_opcode, final_fragment, mask_enable, mask_key,
    // payload_byte, zero pad
    input  wire [wsfb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                               s_tuser,   // req_type
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [wsfb_pkg::M_TDATA_W-1:0]    m_tdata,   // out_byte
    output logic                              m_tlast,   // last_of_run
    output logic [wsfb_pkg::M_TUSER_W-1:0]    m_tuser    // frame_end, unexpected_byte
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    wsfb_pkg::item_t             item_reg;
    wsfb_pkg::item_t             item_next;
    wsfb_pkg::item_t             s_item;
    logic [wsfb_pkg::IDX_W-1:0]  idx_reg;
    logic [wsfb_pkg::IDX_W-1:0]  idx_next;
    wsfb_pkg::frame_state_t      state_reg;
    wsfb_pkg::frame_state_t      state_next;
    wsfb_pkg::frame_state_t      state_after;
    wsfb_pkg::res_t              res;
    logic                        can_take;
    logic                        push;
    logic                        item_done;
    logic                        s_xfer;

    assign s_item.req_type       = wsfb_pkg::req_t'(s_tuser);
    assign s_item.payload_length = s_tdata[30:0];
    assign s_item.frame_opcode   = s_tdata[34:31];
    assign s_item.final_fragment = s_tdata[35];
    assign s_item.mask_enable    = s_tdata[36];
    assign s_item.mask_key       = s_tdata[68:37];
    assign s_item.payload_byte   = s_tdata[76:69];

    assign push      = in_valid_reg && can_take;
    assign item_done = push && res.last_of_run;
    assign s_tready  = !in_valid_reg || item_done;
    assign s_xfer    = s_tvalid && s_tready;

    wsfb_byte_gen u_byte_gen (
        .item       (item_reg),
        .idx        (idx_reg),
        .state      (state_reg),
        .res        (res),
        .state_next (state_after)
    );

    wsfb_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .res      (res),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        state_next    = state_reg;
        if (push) begin
            idx_next = res.last_of_run ? '0 : idx_reg + 4'd1;
        end
        if (item_done) begin
            state_next    = state_after;
            in_valid_next = 1'b0;
        end
        if (s_xfer) begin
            in_valid_next = 1'b1;
            item_next     = s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            idx_reg      <= '0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            idx_reg      <= idx_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    `WSFB_ASSERT_ALWAYS(a_open_matches_count, state_reg.frame_open == |state_reg.bytes_remaining)
    `WSFB_ASSERT_IMP(a_idx_needs_item, idx_reg != '0, in_valid_reg)
    `WSFB_ASSERT_IMP(a_unexp_shape, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0] && ~|m_tdata)
    `WSFB_ASSERT_IMP(a_idx_bounded, in_valid_reg, idx_reg < 4'd14)

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Testbench for websocket_frame_builder: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module testbench;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // payload_length, frame_opcode, final_fragment, mask_enable, mask_key,
    // payload_byte, zero pad
    logic [wsfb_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           s_tuser = 1'b0;   // req_type
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [wsfb_pkg::M_TDATA_W-1:0] m_tdata;          // out_byte
    logic                           m_tlast;          // last_of_run
    logic [wsfb_pkg::M_TUSER_W-1:0] m_tuser;          // frame_end, unexpected_byte

    wsfb_pkg::frame_state_t frame_state = '0;
    wsfb_pkg::res_t         wire_bytes_q[$];
    int                     mismatch_count = 0;
    int                     snd_idle_pct = 0;
    int                     rcv_idle_pct = 0;

    websocket_frame_builder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Work out the wire bytes caused by one accepted item and queue them.
    function automatic void predict_wire_bytes(input wsfb_pkg::item_t it);
        logic [wsfb_pkg::BYTE_W-1:0] hdr [0:wsfb_pkg::HDR_MAX-1];
        logic [wsfb_pkg::LEN_W-1:0]  len;
        logic [wsfb_pkg::BYTE_W-1:0] b;
        logic                        last;
        int                          n;
        int                          sh;
        n = 0;
        len = it.payload_length;
        if (it.req_type == wsfb_pkg::REQ_START) begin
            hdr[n++] = {it.final_fragment, 3'b000, it.frame_opcode};
            if (len < wsfb_pkg::SHORT_LEN_LIM) begin
                hdr[n++] = {it.mask_enable, len[6:0]};
            end else if (len <= wsfb_pkg::MID_LEN_MAX) begin
                hdr[n++] = {it.mask_enable, wsfb_pkg::LEN_CODE_16};
                hdr[n++] = len[15:8];
                hdr[n++] = len[7:0];
            end else begin
                hdr[n++] = {it.mask_enable, wsfb_pkg::LEN_CODE_64};
                // upper half of the 64-bit length is always zero
                repeat (4) hdr[n++] = 8'h00;
                hdr[n++] = {1'b0, len[30:24]};
                hdr[n++] = len[23:16];
                hdr[n++] = len[15:8];
                hdr[n++] = len[7:0];
            end
            if (it.mask_enable) begin
                hdr[n++] = it.mask_key[31:24];
                hdr[n++] = it.mask_key[23:16];
                hdr[n++] = it.mask_key[15:8];
                hdr[n++] = it.mask_key[7:0];
            end
            for (int i = 0; i < n; i++) begin
                last = (i == n - 1);
                wire_bytes_q.push_back('{out_byte: hdr[i], last_of_run: last,
                                         frame_end: last && (len == 0),
                                         unexpected_byte: 1'b0});
            end
            frame_state.bytes_remaining = len;
            frame_state.mask_phase      = 2'd0;
            frame_state.held_mask_key   = it.mask_key;
            frame_state.masking_on      = it.mask_enable;
            frame_state.frame_open      = (len != 0);
        end else if (!frame_state.frame_open) begin
            wire_bytes_q.push_back('{out_byte: 8'h00, last_of_run: 1'b1,
                                     frame_end: 1'b0, unexpected_byte: 1'b1});
        end else begin
            b = it.payload_byte;
            if (frame_state.masking_on) begin
                // phase 0 takes the most significant key byte
                sh = (3 - int'(frame_state.mask_phase)) * 8;
                b = b ^ wsfb_pkg::BYTE_W'(frame_state.held_mask_key >> sh);
            end
            frame_state.mask_phase      = frame_state.mask_phase + 2'd1;
            frame_state.bytes_remaining = frame_state.bytes_remaining - 1'b1;
            if (frame_state.bytes_remaining == 0)
                frame_state.frame_open = 1'b0;
            wire_bytes_q.push_back('{out_byte: b, last_of_run: 1'b1,
                                     frame_end: (frame_state.bytes_remaining == 0),
                                     unexpected_byte: 1'b0});
        end
    endfunction

    always @(posedge aclk) begin
        wsfb_pkg::res_t got;
        wsfb_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{out_byte: m_tdata, last_of_run: m_tlast,
                    frame_end: m_tuser[0], unexpected_byte: m_tuser[1]};
            if (wire_bytes_q.size() == 0) begin
                report_mismatch($sformatf("byte %h with nothing expected", got.out_byte));
            end else begin
                want = wire_bytes_q.pop_front();
                if (got.out_byte != want.out_byte)
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              got.out_byte, want.out_byte));
                if (got.last_of_run != want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              got.last_of_run, want.last_of_run));
                if (got.frame_end != want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              got.frame_end, want.frame_end));
                if (got.unexpected_byte != want.unexpected_byte)
                    report_mismatch($sformatf("unexpected_byte %b, want %b",
                                              got.unexpected_byte, want.unexpected_byte));
            end
        end
    end

    // Called at a rising edge; the sender may first hold s_tvalid low at random, then
    // returns at the edge where the transfer happened.
    task automatic send_item(input wsfb_pkg::item_t it);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {3'b000, it.payload_byte, it.mask_key, it.mask_enable,
                     it.final_fragment, it.frame_opcode, it.payload_length};
        do @(posedge aclk); while (!s_tready);
        predict_wire_bytes(it);
    endtask

    task automatic pause_until_drained();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        do @(posedge aclk); while (wire_bytes_q.size() != 0);
    endtask

    function automatic wsfb_pkg::item_t rand_item();
        wsfb_pkg::item_t it;
        it.req_type       = wsfb_pkg::req_t'($urandom_range(0, 1));
        it.payload_length = wsfb_pkg::LEN_W'($urandom);
        it.frame_opcode   = wsfb_pkg::OPC_W'($urandom);
        it.final_fragment = 1'($urandom_range(0, 1));
        it.mask_enable    = 1'($urandom_range(0, 1));
        it.mask_key       = $urandom;
        it.payload_byte   = wsfb_pkg::BYTE_W'($urandom);
        return it;
    endfunction

    function automatic wsfb_pkg::item_t frame_start(input logic [wsfb_pkg::LEN_W-1:0] len,
                                                    input logic [wsfb_pkg::OPC_W-1:0] opc,
                                                    input logic fin, input logic men,
                                                    input logic [wsfb_pkg::KEY_W-1:0] key);
        wsfb_pkg::item_t it;
        it = rand_item();
        it.req_type       = wsfb_pkg::REQ_START;
        it.payload_length = len;
        it.frame_opcode   = opc;
        it.final_fragment = fin;
        it.mask_enable    = men;
        it.mask_key       = key;
        return it;
    endfunction

    function automatic wsfb_pkg::item_t payload_of(input logic [wsfb_pkg::BYTE_W-1:0] b);
        wsfb_pkg::item_t it;
        it = rand_item();
        it.req_type     = wsfb_pkg::REQ_PAYLOAD;
        it.payload_byte = b;
        return it;
    endfunction

    // Every length class, zero-length frames, stray byte, abandoned frames.
    task automatic test_header_lengths();
        send_item(frame_start(31'd0, 4'h9, 1'b1, 1'b0, 32'h0000_0000));
        send_item(payload_of(8'h55));
        send_item(frame_start(31'd0, 4'hA, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_item(frame_start(31'd125, 4'h1, 1'b0, 1'b0, 32'h0000_0000));
        send_item(frame_start(31'd126, 4'h2, 1'b1, 1'b1, 32'h1234_5678));
        send_item(frame_start(31'd65535, 4'hF, 1'b0, 1'b0, 32'h0000_0000));
        send_item(frame_start(31'd65536, 4'h0, 1'b1, 1'b1, 32'h8000_0001));
        send_item(frame_start(31'h7FFF_FFFF, 4'h8, 1'b1, 1'b1, 32'hDEAD_BEEF));
        send_item(payload_of(8'hFF));
    endtask

    task automatic test_masked_payload();
        send_item(frame_start(31'd6, 4'h2, 1'b1, 1'b1, 32'hA5C3_0FF0));
        send_item(payload_of(8'h00));
        send_item(payload_of(8'hFF));
        send_item(payload_of(8'h3C));
        send_item(payload_of(8'h81));
        send_item(payload_of(8'h7E));
        send_item(payload_of(8'h01));
        send_item(payload_of(8'hAA));
        send_item(frame_start(31'd3, 4'h1, 1'b0, 1'b0, 32'h1122_3344));
        send_item(payload_of(8'hFF));
        send_item(payload_of(8'h00));
        // restart before the last byte of the previous frame
        send_item(frame_start(31'd1, 4'h0, 1'b1, 1'b0, 32'h0000_0000));
        send_item(payload_of(8'h42));
    endtask

    task automatic test_random_frames(input int n_items);
        int              sent;
        int              kind;
        int              cut;
        wsfb_pkg::item_t it;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                // complete frame, sometimes cut short by the next start
                it = frame_start(wsfb_pkg::LEN_W'($urandom_range(0, 12)),
                                 wsfb_pkg::OPC_W'($urandom),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 $urandom);
                cut = it.payload_length;
                if ($urandom_range(0, 5) == 0)
                    cut = $urandom_range(0, cut);
                send_item(it);
                sent++;
                repeat (cut) begin
                    send_item(payload_of(wsfb_pkg::BYTE_W'($urandom)));
                    sent++;
                end
            end else if (kind < 85) begin
                send_item(payload_of(wsfb_pkg::BYTE_W'($urandom)));
                sent++;
            end else if (kind < 96) begin
                it = rand_item();
                it.req_type = wsfb_pkg::REQ_START;
                case ($urandom_range(0, 2))
                    0: it.payload_length = wsfb_pkg::LEN_W'($urandom_range(126, 65535));
                    1: it.payload_length = wsfb_pkg::LEN_W'($urandom_range(65536, 70000));
                    default: ;
                endcase
                send_item(it);
                sent++;
                repeat ($urandom_range(0, 2)) begin
                    send_item(payload_of(wsfb_pkg::BYTE_W'($urandom)));
                    sent++;
                end
            end else begin
                pause_until_drained();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_header_lengths();
        test_masked_payload();
        pause_until_drained();
        snd_idle_pct = 37;
        rcv_idle_pct = 88;
        test_random_frames(30);
        pause_until_drained();
        snd_idle_pct = 88;
        rcv_idle_pct = 37;
        test_random_frames(30);
        pause_until_drained();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_frames(28);
        pause_until_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
